@@ hw/rtl/mtbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-tag balance checker package
// Shared widths, register indexes, event and status codes of the checker.
// ----------------------------------------------------------------------------
package mtbc_pkg;

   localparam int PAIR_W          = 2;
   localparam int TAG_LEN_W       = 3;
   localparam int PAIR_WORD_W     = 64;
   localparam int TAG_LEN_WORD_W  = 24;
   localparam int PAIRS_IN_USE_W  = 3;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = 2;
   localparam int QUEUE_CNT_W     = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAIR_WORD_0  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAG_LENGTH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAIRS_IN_USE = 3'd5;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_BALANCED  = 2'd0,
      STATUS_BAD_CLOSE = 2'd1,
      STATUS_UNCLOSED  = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   // One decided text position, passed from the scanner to the stack engine.
   typedef struct packed {
      op_type              op;
      logic [PAIR_W-1:0]   pair;
      logic                text_end;
   } event_type;

endpackage
`default_nettype wire

@@ hw/rtl/mtbc_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text byte channel
// Valid/ready channel that carries one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface mtbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mtbc_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Check result channel
// Valid/ready channel that carries the verdict for one complete text.
// ----------------------------------------------------------------------------
interface mtbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       balanced;
   logic [1:0] check_status;

   modport source (output valid, output balanced, output check_status, input ready);
   modport sink   (input valid, input balanced, input check_status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mtbc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event queue
// Small first-in first-out buffer between the scanner and the stack engine.
// ----------------------------------------------------------------------------
module mtbc_queue
   import mtbc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  event_type      push_data,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output event_type      head_data
);

   event_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/mtbc_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tag scanner
// Keeps the lookahead window, matches the configured tags at its head, turns
// every text position into a push, pop or nothing, and marks the text end.
// ----------------------------------------------------------------------------
module mtbc_scan
   import mtbc_pkg::*;
#(
   parameter int MAX_PAIRS   = 4,
   parameter int MAX_TAG_LEN = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   mtbc_req_if.sink                        req,
   input  wire logic [PAIR_WORD_W-1:0]     pair_word [MAX_PAIRS],
   input  wire logic [TAG_LEN_WORD_W-1:0]  tag_length_word,
   input  wire logic [PAIRS_IN_USE_W-1:0]  pairs_in_use,
   input  wire logic                       queue_full,
   output logic                            ev_push,
   output event_type                       ev_data
);

   localparam int FW = $clog2(MAX_TAG_LEN + 1);

   logic [7:0]          win_ff [MAX_TAG_LEN];
   logic [7:0]          win_in [MAX_TAG_LEN];
   logic [7:0]          wa     [MAX_TAG_LEN];
   logic [7:0]          dwin   [MAX_TAG_LEN];
   logic [7:0]          shifted[MAX_TAG_LEN];
   logic [FW-1:0]       fill_ff, fill_in;
   logic [FW-1:0]       skip_ff, skip_in;
   logic                drain_ff, drain_in;

   logic                accept, full_window, drain_step, drain_done, decide_en;
   logic [FW-1:0]       navail, davail, skip_next;
   logic                hit;
   op_type              hit_op, dec_op;
   logic [PAIR_W-1:0]   hit_pair;
   logic [TAG_LEN_W-1:0] hit_len, cand_len;
   logic                cand_eq;

   assign req.ready   = !drain_ff && !queue_full;
   assign accept      = req.valid && req.ready;
   assign navail      = fill_ff + FW'(1);
   assign full_window = (navail == FW'(MAX_TAG_LEN));
   assign drain_step  = drain_ff && !queue_full;
   assign drain_done  = drain_step && (fill_ff == FW'(1));
   assign decide_en   = drain_step || (accept && !req.last_byte && full_window);
   assign davail      = drain_ff ? fill_ff : navail;

   // Window with the incoming byte appended, and the window being decided.
   always_comb begin
      for (int k = 0; k < MAX_TAG_LEN; k++) begin
         wa[k]   = (FW'(k) == fill_ff) ? req.text_byte : win_ff[k];
         dwin[k] = drain_ff ? win_ff[k] : wa[k];
      end
      for (int k = 0; k < MAX_TAG_LEN - 1; k++) begin
         shifted[k] = dwin[k + 1];
      end
      shifted[MAX_TAG_LEN-1] = 8'h00;
   end

   // Try the active pairs in order, opening tag before closing tag.
   always_comb begin
      hit      = 1'b0;
      hit_op   = OP_NONE;
      hit_pair = '0;
      hit_len  = '0;
      cand_len = '0;
      cand_eq  = 1'b0;
      for (int p = 0; p < MAX_PAIRS; p++) begin
         for (int c = 0; c < 2; c++) begin
            cand_len = tag_length_word[TAG_LEN_W*(2*p+c) +: TAG_LEN_W];
            cand_eq  = 1'b1;
            for (int k = 0; k < MAX_TAG_LEN; k++) begin
               if ((TAG_LEN_W'(k) < cand_len) &&
                   (dwin[k] != pair_word[p][32*c + 8*k +: 8])) begin
                  cand_eq = 1'b0;
               end
            end
            if (!hit && cand_eq && (cand_len != '0) &&
                (4'(cand_len) <= 4'(MAX_TAG_LEN)) && (4'(cand_len) <= 4'(davail)) &&
                (PAIRS_IN_USE_W'(p) < pairs_in_use)) begin
               hit      = 1'b1;
               hit_op   = (c == 1) ? OP_POP : OP_PUSH;
               hit_pair = PAIR_W'(p);
               hit_len  = cand_len;
            end
         end
      end
   end

   // Positions inside a matched tag are skipped.
   always_comb begin
      dec_op    = OP_NONE;
      skip_next = skip_ff;
      if (skip_ff != '0) begin
         skip_next = skip_ff - FW'(1);
      end else if (hit) begin
         dec_op    = hit_op;
         skip_next = FW'(hit_len - TAG_LEN_W'(1));
      end
   end

   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      skip_in  = skip_ff;
      drain_in = drain_ff;
      if (decide_en) begin
         skip_in = skip_next;
      end
      if (accept) begin
         if (req.last_byte) begin
            win_in   = wa;
            fill_in  = navail;
            drain_in = 1'b1;
         end else if (full_window) begin
            win_in  = shifted;
            fill_in = FW'(MAX_TAG_LEN - 1);
         end else begin
            win_in  = wa;
            fill_in = navail;
         end
      end else if (drain_step) begin
         if (drain_done) begin
            for (int k = 0; k < MAX_TAG_LEN; k++) begin
               win_in[k] = 8'h00;
            end
            fill_in  = '0;
            skip_in  = '0;
            drain_in = 1'b0;
         end else begin
            win_in  = shifted;
            fill_in = fill_ff - FW'(1);
         end
      end
   end

   assign ev_push          = decide_en && ((dec_op != OP_NONE) || drain_done);
   assign ev_data.op       = dec_op;
   assign ev_data.pair     = hit_pair;
   assign ev_data.text_end = drain_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         skip_ff  <= '0;
         drain_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         skip_ff  <= skip_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/mtbc_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack engine
// Applies push and pop events to the open-pair stack, tracks the first
// failure and registers the verdict at the end of each text.
// ----------------------------------------------------------------------------
module mtbc_stack
   import mtbc_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  head_valid,
   input  event_type  head_data,
   output logic       pop,
   mtbc_rsp_if.source rsp
);

   localparam int LVW = $clog2(STACK_DEPTH + 1);
   localparam int AW  = $clog2(STACK_DEPTH);

   logic [PAIR_W-1:0]  stack_mem [STACK_DEPTH];
   logic [PAIR_W-1:0]  rd_ff;
   logic [PAIR_W-1:0]  top_ff, top_in;
   logic [PAIR_W-1:0]  sub_ff, sub_in;
   logic [LVW-1:0]     level_ff, level_in;
   status_type         fail_ff, fail_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               out_free, mem_we;
   logic [AW-1:0]      rd_addr;
   status_type         verdict;

   // Top and second entry live in registers; the memory read runs one entry
   // further down so that back-to-back pops always find the next entry ready.
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = head_valid && (!head_data.text_end || out_free);

   always_comb begin
      top_in        = top_ff;
      sub_in        = sub_ff;
      level_in      = level_ff;
      fail_in       = fail_ff;
      mem_we        = 1'b0;
      verdict       = STATUS_BALANCED;
      rsp_valid_in  = rsp.ready ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      if (pop) begin
         if (fail_ff == STATUS_BALANCED) begin
            unique case (head_data.op)
               OP_PUSH: begin
                  if (level_ff == LVW'(STACK_DEPTH)) begin
                     fail_in = STATUS_OVERFLOW;
                  end else begin
                     mem_we   = 1'b1;
                     level_in = level_ff + LVW'(1);
                     sub_in   = top_ff;
                     top_in   = head_data.pair;
                  end
               end
               OP_POP: begin
                  if ((level_ff == '0) || (top_ff != head_data.pair)) begin
                     fail_in = STATUS_BAD_CLOSE;
                  end else begin
                     level_in = level_ff - LVW'(1);
                     top_in   = sub_ff;
                     sub_in   = rd_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         if (head_data.text_end) begin
            if (fail_in != STATUS_BALANCED) begin
               verdict = fail_in;
            end else if (level_in != '0) begin
               verdict = STATUS_UNCLOSED;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = verdict;
            level_in      = '0;
            fail_in       = STATUS_BALANCED;
         end
      end
   end

   assign rd_addr = AW'(level_in - LVW'(3));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[AW'(level_ff)] <= head_data.pair;
      end
      if (int'(rd_addr) < STACK_DEPTH) begin
         rd_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         fail_ff      <= STATUS_BALANCED;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      sub_ff        <= sub_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.check_status = rsp_status_ff;
   assign rsp.balanced     = (rsp_status_ff == STATUS_BALANCED);

endmodule
`default_nettype wire

@@ hw/rtl/multi_tag_balance_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-tag balance checker
// Checks a byte stream for properly nested pairs of configurable tags.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one text byte per beat plus last_byte, which marks the
//   final byte of a text. rsp_chan returns one beat per text: balanced and
//   check_status (balanced, bad close, unclosed open, stack overflow).
//   The csr_ port writes the tag pairs, the tag lengths and the number of
//   pairs in use; write it only while no text is in flight.
//   Throughput is one byte per cycle while the event queue has room and no flush runs.
//   After the last beat of a text the scanner flushes its lookahead window, one position
//   per cycle while the queue has room, and holds off req_chan until the bytes still in
//   the window are decided. The end-of-text event then passes through the event queue
//   to the stack engine, which registers the verdict for rsp_chan.
//   The scanner and the stack engine are joined by a four-entry event queue,
//   and the verdict sits in an output register, so the next text is taken
//   while a verdict still waits. If rsp_chan stalls, the stack engine halts
//   at the next end-of-text event and the queue then backs up into req_chan.
//   Reset clears the text state and sets the registers to their defaults
//   (one pair in use, all tags of length zero).
// ----------------------------------------------------------------------------
module multi_tag_balance_checker
   import mtbc_pkg::*;
#(
   parameter int MAX_PAIRS   = 4,
   parameter int MAX_TAG_LEN = 4,
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   mtbc_req_if.sink                     req_chan,
   mtbc_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_write_data
);

   // Configuration registers. Pair words beyond MAX_PAIRS are never tried,
   // so writes to them are dropped.
   logic [PAIR_WORD_W-1:0]    pair_word_ff [MAX_PAIRS];
   logic [TAG_LEN_WORD_W-1:0] tag_length_ff;
   logic [PAIRS_IN_USE_W-1:0] pairs_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < MAX_PAIRS; p++) begin
            pair_word_ff[p] <= '0;
         end
         tag_length_ff   <= '0;
         pairs_in_use_ff <= PAIRS_IN_USE_W'(1);
      end else if (csr_write_enable) begin
         for (int p = 0; p < MAX_PAIRS; p++) begin
            if (csr_index == CSR_PAIR_WORD_0 + CSR_INDEX_W'(p)) begin
               pair_word_ff[p] <= csr_write_data;
            end
         end
         if (csr_index == CSR_TAG_LENGTH) begin
            tag_length_ff <= csr_write_data[TAG_LEN_WORD_W-1:0];
         end
         if (csr_index == CSR_PAIRS_IN_USE) begin
            pairs_in_use_ff <= csr_write_data[PAIRS_IN_USE_W-1:0];
         end
      end
   end

   // Front: window and tag matching. Each matched tag and each text end becomes an event.
   logic       ev_push;
   event_type  ev_data;
   logic       q_full;
   logic       q_pop;
   logic       q_head_valid;
   event_type  q_head;

   mtbc_scan #(
      .MAX_PAIRS   (MAX_PAIRS),
      .MAX_TAG_LEN (MAX_TAG_LEN)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .req             (req_chan),
      .pair_word       (pair_word_ff),
      .tag_length_word (tag_length_ff),
      .pairs_in_use    (pairs_in_use_ff),
      .queue_full      (q_full),
      .ev_push         (ev_push),
      .ev_data         (ev_data)
   );

   mtbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (ev_push),
      .push_data  (ev_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head)
   );

   // Back: stack of open pairs, failure tracking and the verdict register.
   mtbc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head),
      .pop        (q_pop),
      .rsp        (rsp_chan)
   );

`ifndef SYNTHESIS
   // The two verdict fields always agree.
   a_verdict_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.balanced == (rsp_chan.check_status == STATUS_BALANCED)))
      else $error("balanced flag disagrees with check_status");

   // An end-of-text event leaving the queue always lands in the output register.
   a_end_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.text_end) |=> rsp_chan.valid)
      else $error("end of text consumed without a verdict");

   // The scanner flushes its window after a last beat before taking more text.
   a_flush_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_byte) |=> !req_chan.ready)
      else $error("new text taken before the window was flushed");

   // The scanner never produces an event into a full queue.
   a_no_event_lost: assert property (@(posedge clock) disable iff (reset)
      ev_push |-> !q_full)
      else $error("event pushed into a full queue");
`endif

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-tag balance checker testbench
// Streams texts through the checker and compares every verdict beat with a
// cycle-free predictor of the tag scanner and its pair stack. Directed texts
// cover the register corner cases, stack overflow and failure precedence.
// Random texts follow under many tag settings, with bursty sending and a
// stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
   import mtbc_pkg::*;

   localparam int MAX_PAIRS     = 4;
   localparam int MAX_TAG_LEN   = 4;
   localparam int STACK_DEPTH   = 64;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_BYTES  = 1700;
   // Quiet time after the last owed verdict has arrived, before register writes.
   localparam int SETTLE_CYCLES = 12;
   localparam int TIMEOUT_NS    = 4_000_000;

   // Indexes past the last register; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   // Tag lengths of the directed setting, closing tag of pair 3 first:
   // pair 3 never matches (open of length zero, close longer than allowed).
   localparam logic [TAG_LEN_WORD_W-1:0] DIRECTED_LENGTHS =
      {3'd5, 3'd0, 3'd1, 3'd1, 3'd4, 3'd3, 3'd1, 3'd1};

   typedef struct packed {
      logic       balanced;
      status_type check_status;
   } verdict_type;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_LONG_STALL} rx_mode_type;
   typedef enum int {SET_MIXED, SET_LONG_TAGS, SET_SHORT_TAGS} setting_kind_type;

   bit                     clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   mtbc_req_if req_bus ();
   mtbc_rsp_if rsp_bus ();

   multi_tag_balance_checker #(
      .MAX_PAIRS   (MAX_PAIRS),
      .MAX_TAG_LEN (MAX_TAG_LEN),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // -------------------------------------------------------------------------
   // Predictor state: a mirror of the registers and of the per-text state.
   // -------------------------------------------------------------------------
   logic [PAIR_WORD_W-1:0]    cfg_pair_word [MAX_PAIRS];
   logic [TAG_LEN_WORD_W-1:0] cfg_tag_lengths;
   logic [PAIRS_IN_USE_W-1:0] cfg_pairs_in_use;

   logic [7:0]        window_bytes [MAX_TAG_LEN];
   int unsigned       window_count;
   int unsigned       skip_count;
   int unsigned       nest_level;
   logic [PAIR_W-1:0] nest_stack [STACK_DEPTH];
   status_type        first_failure;

   // Verdicts still owed by the block, oldest first.
   verdict_type verdict_queue [$];

   // Stimulus bookkeeping.
   logic [7:0] text_buf [$];
   logic [7:0] tag_alphabet [4];
   int         burst_left;
   int         error_count;
   int         bytes_sent;
   int         texts_sent;
   int         settings_used;
   int         status_seen [4];

   // Receiver stall pattern.
   rx_mode_type rx_mode      = RX_ALWAYS;
   int          rx_mode_left = 0;
   int          rx_hold      = 0;
   bit          rx_level     = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic int unsigned tag_length(int unsigned pair, bit closing);
      return cfg_tag_lengths[3 * (2 * pair + closing) +: TAG_LEN_W];
   endfunction

   function automatic logic [7:0] tag_char(int unsigned pair, bit closing, int unsigned k);
      return cfg_pair_word[pair][(closing ? 32 : 0) + 8 * k +: 8];
   endfunction

   function automatic bit tag_at_window(int unsigned pair, bit closing, int unsigned avail);
      int unsigned len;
      len = tag_length(pair, closing);
      if (len == 0 || len > MAX_TAG_LEN || len > avail) return 1'b0;
      for (int unsigned k = 0; k < len; k++) begin
         if (window_bytes[k] != tag_char(pair, closing, k)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Settles the text position at the head of the window.
   function automatic void decide_position(int unsigned avail);
      int unsigned active;
      active = (cfg_pairs_in_use > MAX_PAIRS) ? MAX_PAIRS : cfg_pairs_in_use;
      if (skip_count > 0) begin
         skip_count--;
         return;
      end
      if (first_failure != STATUS_BALANCED) return;
      for (int unsigned p = 0; p < active; p++) begin
         if (tag_at_window(p, 1'b0, avail)) begin
            if (nest_level >= STACK_DEPTH) begin
               first_failure = STATUS_OVERFLOW;
            end else begin
               nest_stack[nest_level] = PAIR_W'(p);
               nest_level++;
            end
            skip_count = tag_length(p, 1'b0) - 1;
            return;
         end
         if (tag_at_window(p, 1'b1, avail)) begin
            if (nest_level == 0 || nest_stack[nest_level - 1] != PAIR_W'(p)) begin
               first_failure = STATUS_BAD_CLOSE;
            end else begin
               nest_level--;
            end
            skip_count = tag_length(p, 1'b1) - 1;
            return;
         end
      end
   endfunction

   function automatic void shift_window();
      for (int k = 0; k < MAX_TAG_LEN - 1; k++) window_bytes[k] = window_bytes[k + 1];
      window_bytes[MAX_TAG_LEN - 1] = 8'h00;
      if (window_count > 0) window_count--;
   endfunction

   function automatic void clear_text_state();
      foreach (window_bytes[k]) window_bytes[k] = 8'h00;
      window_count  = 0;
      skip_count    = 0;
      nest_level    = 0;
      first_failure = STATUS_BALANCED;
   endfunction

   // Advances the mirror by one accepted text byte; a last byte owes a verdict.
   function automatic void predict_beat(logic [7:0] text_byte, logic last_byte);
      status_type  verdict;
      verdict_type owed;
      if (window_count < MAX_TAG_LEN) begin
         window_bytes[window_count] = text_byte;
         window_count++;
      end
      if (!last_byte) begin
         if (window_count >= MAX_TAG_LEN) begin
            decide_position(window_count);
            shift_window();
         end
         return;
      end
      while (window_count > 0) begin
         decide_position(window_count);
         shift_window();
      end
      if (first_failure != STATUS_BALANCED) verdict = first_failure;
      else if (nest_level > 0)              verdict = STATUS_UNCLOSED;
      else                                  verdict = STATUS_BALANCED;
      owed.balanced     = (verdict == STATUS_BALANCED);
      owed.check_status = verdict;
      verdict_queue.push_back(owed);
      clear_text_state();
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index < CSR_TAG_LENGTH) cfg_pair_word[index - CSR_PAIR_WORD_0] = data;
      else if (index == CSR_TAG_LENGTH) cfg_tag_lengths = data[TAG_LEN_WORD_W-1:0];
      else if (index == CSR_PAIRS_IN_USE) cfg_pairs_in_use = data[PAIRS_IN_USE_W-1:0];
   endtask

   // Sends one text byte. The sender runs in bursts; between bursts valid
   // drops for a random number of cycles, sometimes none at all.
   task automatic send_beat(input logic [7:0] text_byte, input logic last_byte);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.text_byte <= text_byte;
      req_bus.last_byte <= last_byte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_beat(text_byte, last_byte);
      bytes_sent++;
      if (last_byte) texts_sent++;
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_beat(text_buf[i], i == text_buf.size() - 1);
   endtask

   // Holds the sender off until every owed verdict has arrived, then lets the
   // block settle so that register writes land while it is idle.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // Receiver: switches between always ready, coin flips and long stalls.
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 2));
         rx_mode_left = $urandom_range(150, 300);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         RX_ALWAYS: rsp_bus.ready <= 1'b1;
         RX_COIN:   rsp_bus.ready <= ($urandom_range(0, 9) < 7);
         default: begin
            if (rx_hold == 0) begin
               rx_level = ~rx_level;
               rx_hold  = rx_level ? $urandom_range(1, 10) : $urandom_range(5, 30);
            end else begin
               rx_hold--;
            end
            rsp_bus.ready <= rx_level;
         end
      endcase
   end

   // Verdict checker: every accepted beat is matched with the oldest owed one.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (verdict_queue.size() == 0) begin
            $error("verdict beat with none owed: balanced %0d, check_status %0d",
                   rsp_bus.balanced, rsp_bus.check_status);
            error_count++;
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_bus.balanced !== want.balanced) begin
               $error("balanced: expected %0d, actual %0d", want.balanced, rsp_bus.balanced);
               error_count++;
            end
            if (rsp_bus.check_status !== want.check_status) begin
               $error("check_status: expected %0d, actual %0d",
                      want.check_status, rsp_bus.check_status);
               error_count++;
            end
            status_seen[want.check_status]++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Text generators
   // -------------------------------------------------------------------------
   // Tags that can never match still get some of their bytes, so near misses
   // show up in the text.
   function automatic void add_tag(int unsigned pair, bit closing);
      int unsigned len;
      len = tag_length(pair, closing);
      if (len == 0 || len > MAX_TAG_LEN) len = $urandom_range(1, MAX_TAG_LEN);
      for (int unsigned k = 0; k < len; k++) text_buf.push_back(tag_char(pair, closing, k));
   endfunction

   function automatic void add_filler();
      if ($urandom_range(0, 1) == 0) text_buf.push_back(tag_alphabet[$urandom_range(0, 3)]);
      else text_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Pairs whose two tags can both match under the current setting.
   function automatic void usable_pairs(ref int unsigned usable [$]);
      int unsigned active;
      usable.delete();
      active = (cfg_pairs_in_use > MAX_PAIRS) ? MAX_PAIRS : cfg_pairs_in_use;
      for (int unsigned p = 0; p < active; p++) begin
         if (tag_length(p, 1'b0) inside {[1:MAX_TAG_LEN]} &&
             tag_length(p, 1'b1) inside {[1:MAX_TAG_LEN]})
            usable.push_back(p);
      end
   endfunction

   // A properly nested sequence of tags with filler bytes mixed in.
   function automatic void build_nested_text(int steps, int max_depth);
      int unsigned nest [$];
      int unsigned usable [$];
      int unsigned pick;
      int unsigned choice;
      text_buf.delete();
      usable_pairs(usable);
      for (int s = 0; s < steps; s++) begin
         choice = $urandom_range(0, 9);
         if (usable.size() > 0 && choice < 4 && nest.size() < max_depth) begin
            pick = usable[$urandom_range(0, usable.size() - 1)];
            add_tag(pick, 1'b0);
            nest.push_back(pick);
         end else if (nest.size() > 0 && choice < 8) begin
            add_tag(nest.pop_back(), 1'b1);
         end else begin
            add_filler();
         end
      end
      while (nest.size() > 0) add_tag(nest.pop_back(), 1'b1);
      if (text_buf.size() == 0 || $urandom_range(0, 2) == 0) add_filler();
   endfunction

   // Nesting near the stack depth, sometimes left open.
   function automatic void build_deep_text();
      int unsigned nest [$];
      int unsigned usable [$];
      int unsigned pick;
      text_buf.delete();
      usable_pairs(usable);
      if (usable.size() == 0) begin
         add_filler();
         return;
      end
      repeat ($urandom_range(STACK_DEPTH - 8, STACK_DEPTH + 4)) begin
         pick = usable[$urandom_range(0, usable.size() - 1)];
         add_tag(pick, 1'b0);
         nest.push_back(pick);
      end
      while (nest.size() > 0 && $urandom_range(0, 49) != 0) add_tag(nest.pop_back(), 1'b1);
      add_filler();
   endfunction

   // A nested text with one defect: a lost byte, a corrupted byte or a
   // stray tag at either end.
   function automatic void build_broken_text();
      int unsigned spot;
      int unsigned stray;
      logic [7:0]  saved [$];
      build_nested_text($urandom_range(2, 12), $urandom_range(1, 6));
      spot = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 2))
         0: if (text_buf.size() > 1) text_buf.delete(spot);
         1: text_buf[spot] = 8'($urandom_range(0, 255));
         default: begin
            stray = $urandom_range(0, MAX_PAIRS - 1);
            if ($urandom_range(0, 1) == 0) begin
               add_tag(stray, 1'($urandom_range(0, 1)));
            end else begin
               saved = text_buf;
               text_buf.delete();
               add_tag(stray, 1'($urandom_range(0, 1)));
               foreach (saved[i]) text_buf.push_back(saved[i]);
            end
         end
      endcase
   endfunction

   function automatic void build_noise_text();
      text_buf.delete();
      repeat ($urandom_range(1, 10)) text_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Draws a fresh register setting. Tag bytes come mostly from a small
   // alphabet so that tags overlap and filler forms accidental tags; the
   // bits above each register's width are random to check the masking.
   task automatic random_settings(input setting_kind_type kind);
      logic [CSR_DATA_W-1:0]     word;
      logic [TAG_LEN_WORD_W-1:0] lengths;
      int unsigned               draw;
      foreach (tag_alphabet[a]) tag_alphabet[a] = 8'($urandom_range(0, 255));
      for (int p = 0; p < MAX_PAIRS; p++) begin
         word = {$urandom, $urandom};
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(0, 4) != 0) word[8 * k +: 8] = tag_alphabet[$urandom_range(0, 3)];
         end
         write_csr(CSR_PAIR_WORD_0 + CSR_INDEX_W'(p), word);
      end
      for (int f = 0; f < 2 * MAX_PAIRS; f++) begin
         draw = $urandom_range(0, 9);
         case (kind)
            SET_LONG_TAGS:  lengths[3 * f +: 3] = 3'(MAX_TAG_LEN);
            SET_SHORT_TAGS: lengths[3 * f +: 3] = 3'd1;
            default:
               if (draw == 0)      lengths[3 * f +: 3] = 3'd0;
               else if (draw == 1) lengths[3 * f +: 3] = 3'($urandom_range(5, 7));
               else                lengths[3 * f +: 3] = 3'($urandom_range(1, MAX_TAG_LEN));
         endcase
      end
      word = {$urandom, $urandom};
      word[TAG_LEN_WORD_W-1:0] = lengths;
      write_csr(CSR_TAG_LENGTH, word);
      word = {$urandom, $urandom};
      draw = $urandom_range(0, 9);
      case (kind)
         SET_LONG_TAGS:  word[PAIRS_IN_USE_W-1:0] = 3'(MAX_PAIRS);
         SET_SHORT_TAGS: word[PAIRS_IN_USE_W-1:0] = 3'd1;
         default:
            if (draw == 0)      word[PAIRS_IN_USE_W-1:0] = 3'd0;
            else if (draw == 1) word[PAIRS_IN_USE_W-1:0] = 3'($urandom_range(5, 7));
            else                word[PAIRS_IN_USE_W-1:0] = 3'($urandom_range(1, MAX_PAIRS));
      endcase
      write_csr(CSR_PAIRS_IN_USE, word);
      if ($urandom_range(0, 3) == 0) begin
         write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, {$urandom, $urandom});
      end
      settings_used++;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // With the reset setting every tag has length zero, so nothing matches,
   // not even bytes equal to the all-zero tag words.
   task automatic test_reset_defaults();
      text_buf = {8'h00, 8'hFF};
      send_text();
   endtask

   // Pair 0 is "(" ")", pair 1 "<b>" "</b>", pair 2 is the byte extremes
   // 0xFF and 0x00, and pair 3 can never match.
   task automatic test_directed_tags();
      wait_idle();
      write_csr(CSR_PAIR_WORD_0 + 3'd0, {32'h0000_0029, 32'h0000_0028});
      write_csr(CSR_PAIR_WORD_0 + 3'd1, {32'h3E62_2F3C, 32'h003E_623C});
      write_csr(CSR_PAIR_WORD_0 + 3'd2, {32'hFFFF_FF00, 32'h0000_00FF});
      write_csr(CSR_PAIR_WORD_0 + 3'd3, {32'h7979_7979, 32'h7878_7878});
      write_csr(CSR_TAG_LENGTH, 64'(DIRECTED_LENGTHS));
      write_csr(CSR_PAIRS_IN_USE, 64'(MAX_PAIRS));
      settings_used++;
      text_buf = {8'h28, 8'h29};                      // simple pair
      send_text();
      text_buf = {8'h28, 8'h3C, 8'h2F, 8'h62, 8'h3E}; // close of the wrong pair
      send_text();
      text_buf = {8'hFF, 8'h00};                      // byte extremes as tags
      send_text();
      text_buf = {8'h29, 8'h28, 8'h28};               // close on empty stack wins
      send_text();
      text_buf = {8'h28, 8'h3C, 8'h62, 8'h3E};        // left open
      send_text();
      text_buf = {8'h78, 8'h79};                      // zero and too-long lengths
      send_text();
      text_buf = {8'h3C, 8'h62};                      // tag cut off by the end
      send_text();
   endtask

   // No pairs in use, then a count above the maximum, which saturates.
   // Writes to the spare indexes and junk above the register widths must
   // not disturb the setting.
   task automatic test_pair_count_limits();
      logic [CSR_DATA_W-1:0] word;
      wait_idle();
      word = {$urandom, $urandom};
      word[PAIRS_IN_USE_W-1:0] = 3'd0;
      write_csr(CSR_PAIRS_IN_USE, word);
      write_csr(CSR_SPARE_A, {CSR_DATA_W{1'b1}});
      write_csr(CSR_SPARE_B, {$urandom, $urandom});
      settings_used++;
      text_buf = {8'h28, 8'h28};
      send_text();
      wait_idle();
      write_csr(CSR_TAG_LENGTH, {40'hFF_FFFF_FFFF, DIRECTED_LENGTHS});
      write_csr(CSR_PAIRS_IN_USE, {61'h0A5A_5A5A_5A5A_5A5A, 3'd7});
      settings_used++;
      text_buf = {8'hFF};                             // pair 2 opens, never closes
      send_text();
      text_buf = {8'h3C, 8'h62, 8'h3E, 8'h3C, 8'h2F, 8'h62, 8'h3E};
      send_text();
   endtask

   // One opening tag more than the stack holds, then exactly a full stack.
   task automatic test_stack_overflow();
      wait_idle();
      write_csr(CSR_PAIRS_IN_USE, 64'd1);
      settings_used++;
      text_buf.delete();
      repeat (STACK_DEPTH + 1) text_buf.push_back(8'h28);
      text_buf.push_back(8'h29);
      send_text();
      text_buf.delete();
      repeat (STACK_DEPTH) text_buf.push_back(8'h28);
      repeat (STACK_DEPTH) text_buf.push_back(8'h29);
      send_text();
   endtask

   // Phases of random texts, each under a fresh setting. The first two
   // phases take the longest and the shortest tags with all or one pair.
   task automatic test_random_texts();
      int phase;
      int start_bytes;
      int kind;
      phase       = 0;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         wait_idle();
         if (phase == 0)      random_settings(SET_LONG_TAGS);
         else if (phase == 1) random_settings(SET_SHORT_TAGS);
         else                 random_settings(SET_MIXED);
         repeat ($urandom_range(6, 14)) begin
            kind = $urandom_range(0, 99);
            if (kind < 2)       build_deep_text();
            else if (kind < 72) build_nested_text($urandom_range(1, 14), $urandom_range(1, 8));
            else if (kind < 90) build_broken_text();
            else                build_noise_text();
            send_text();
         end
         phase++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_PAIR_WORD_0;
      csr_write_data    = '0;
      req_bus.valid     = 1'b0;
      req_bus.text_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      burst_left        = 0;
      error_count       = 0;
      bytes_sent        = 0;
      texts_sent        = 0;
      settings_used     = 1;
      foreach (status_seen[s]) status_seen[s] = 0;
      foreach (tag_alphabet[a]) tag_alphabet[a] = 8'h00;
      foreach (cfg_pair_word[p]) cfg_pair_word[p] = '0;
      foreach (nest_stack[d]) nest_stack[d] = '0;
      cfg_tag_lengths  = '0;
      cfg_pairs_in_use = 3'd1;
      clear_text_state();

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_tags();
      test_pair_count_limits();
      test_stack_overflow();
      test_random_texts();

      // Drain the last verdicts and give stray beats a chance to show up.
      wait_idle();

      $display("Checked %0d texts (%0d text bytes) under %0d register settings.",
               texts_sent, bytes_sent, settings_used);
      $display("Verdicts: %0d balanced, %0d bad close, %0d unclosed, %0d overflow.",
               status_seen[STATUS_BALANCED], status_seen[STATUS_BAD_CLOSE],
               status_seen[STATUS_UNCLOSED], status_seen[STATUS_OVERFLOW]);
      if (error_count == 0 && verdict_queue.size() == 0) begin
         $display("** multi_tag_balance_checker: PASSED **");
      end else begin
         $display("** multi_tag_balance_checker: FAILED **");
      end
      $finish;
   end

   // Watchdog: a run that hangs on a handshake ends here.
   initial begin
      #(TIMEOUT_NS);
      $display("** multi_tag_balance_checker: FAILED **");
      $finish;
   end

endmodule
